// ===== rtl/distance_lod_selector_hysteresis_core_assert.svh =====
// ----------------------------------------------------------------------------
// dlsh assertion macros
// concurrent checks clocked on i_clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef DISTANCE_LOD_SELECTOR_HYSTERESIS_CORE_ASSERT_SVH
`define DISTANCE_LOD_SELECTOR_HYSTERESIS_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define DLSH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define DLSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dlsh_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsh_pkg
// shared types and constants of the distance lod selector
// ----------------------------------------------------------------------------
package dlsh_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int IDX_W       = 6;
    localparam int EXT_W       = IDX_W + SLOT_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0]  TIER_FULL   = 2'd0;
    localparam logic [1:0]  TIER_RATE   = 2'd1;
    localparam logic [1:0]  TIER_SKEL   = 2'd2;
    localparam logic [1:0]  TIER_IMP    = 2'd3;
    localparam logic [20:0] ONE_FX      = 21'd16;
    localparam logic [15:0] MIN_SIZE_FX = 16'd64;
    localparam logic [6:0]  HOLD_MAX    = 7'd127;

    localparam logic [1:0]  CFG_ENABLE  = 2'd0;
    localparam logic [1:0]  CFG_START   = 2'd1;
    localparam logic [1:0]  CFG_END     = 2'd2;
    localparam logic [1:0]  CFG_HOLD    = 2'd3;

    localparam logic [19:0] RST_START   = 20'd9600;
    localparam logic [19:0] RST_END     = 20'd38400;
    localparam logic [6:0]  RST_HOLD    = 7'd8;

    typedef enum logic [1:0] {
        MODE_SELECT = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_OPEN   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_bstate;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  instance_req;
        logic [19:0] distance;
        logic [15:0] projected_size;
        logic        visible;
        logic        shadow_visible;
        logic        cinematic;
        logic [31:0] frame_index;
    } t_req;

    typedef struct packed {
        logic [1:0] tier;
        logic       update_pose;
        logic       slot_valid;
    } t_rsp;

    typedef struct packed {
        logic        lod_enable;
        logic [19:0] lod_start;
        logic [19:0] lod_end;
        logic [6:0]  hold_frames;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [SLOT_W-1:0] addr;
        logic              in_range;
        logic              force_full;
        logic [1:0]        want;
        logic              hit_rate;
        logic              hit_skel;
        logic              hit_imp;
        logic              frame_nz;
    } t_item;

    typedef struct packed {
        logic [1:0] committed;
        logic [1:0] pending;
        logic [6:0] hold;
        logic       upd_nz;
    } t_slot;

endpackage

// ===== rtl/dlsh_front.sv =====
// ----------------------------------------------------------------------------
// dlsh_front
// takes requests, works out wanted tier and frame phase, pushes into queue
// ----------------------------------------------------------------------------
module dlsh_front (
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  dlsh_pkg::t_req    i_req,
    input  dlsh_pkg::t_cfg    i_cfg,
    output logic              o_push,
    output dlsh_pkg::t_item   o_item,
    input  logic              i_q_ready
);

    logic [20:0] w_start;
    logic [20:0] w_end;
    logic [21:0] w_mid;
    logic [21:0] w_dist2;
    logic [1:0]  w_want;
    logic [dlsh_pkg::EXT_W-1:0] w_ext;

    // frame mod 3 by folding, since 2^16, 2^8, 2^6, 2^4 and 2^2 are 1 mod 3
    logic [16:0] w_f1;
    logic [9:0]  w_f2;
    logic [6:0]  w_f3;
    logic [4:0]  w_f4;
    logic [3:0]  w_f5;
    logic        w_mod3_zero;

    always_comb begin
        w_f1 = {1'b0, i_req.frame_index[31:16]} + {1'b0, i_req.frame_index[15:0]};
        w_f2 = {1'b0, w_f1[16:8]} + {2'b00, w_f1[7:0]};
        w_f3 = {3'b000, w_f2[9:6]} + {1'b0, w_f2[5:0]};
        w_f4 = {2'b00, w_f3[6:4]} + {1'b0, w_f3[3:0]};
        w_f5 = {1'b0, w_f4[4:2]} + {2'b00, w_f4[1:0]};
        w_mod3_zero = (w_f5 == 4'd0) || (w_f5 == 4'd3) || (w_f5 == 4'd6)
                   || (w_f5 == 4'd9);
    end

    always_comb begin
        w_start = {1'b0, i_cfg.lod_start};
        if (i_cfg.lod_end <= i_cfg.lod_start) begin
            w_end = w_start + dlsh_pkg::ONE_FX;
        end else begin
            w_end = {1'b0, i_cfg.lod_end};
        end
        w_mid   = {1'b0, w_start} + {1'b0, w_end};
        w_dist2 = {1'b0, i_req.distance, 1'b0};

        if (!i_req.visible && !i_req.shadow_visible) begin
            w_want = dlsh_pkg::TIER_IMP;
        end else if (({1'b0, i_req.distance} >= w_end)
                  || (i_req.projected_size < dlsh_pkg::MIN_SIZE_FX)) begin
            w_want = dlsh_pkg::TIER_IMP;
        end else if (w_dist2 >= w_mid) begin
            w_want = dlsh_pkg::TIER_SKEL;
        end else if (i_req.distance >= i_cfg.lod_start) begin
            w_want = dlsh_pkg::TIER_RATE;
        end else begin
            w_want = dlsh_pkg::TIER_FULL;
        end
    end

    always_comb begin
        w_ext = dlsh_pkg::EXT_W'(i_req.instance_req);

        o_item.mode       = dlsh_pkg::t_mode'(i_req.mode);
        o_item.addr       = w_ext[dlsh_pkg::SLOT_W-1:0];
        o_item.in_range   = (i_req.instance_req != '0)
                         && (32'(i_req.instance_req) < 32'(dlsh_pkg::NUM_SLOTS));
        o_item.force_full = !i_cfg.lod_enable || i_req.cinematic;
        o_item.want       = w_want;
        o_item.hit_rate   = !i_req.frame_index[0];
        o_item.hit_skel   = w_mod3_zero;
        o_item.hit_imp    = (i_req.frame_index[2:0] == 3'd0);
        o_item.frame_nz   = (i_req.frame_index != '0);

        o_req_ready = i_q_ready;
        o_push      = i_req_valid && i_q_ready;
    end

endmodule

// ===== rtl/dlsh_queue.sv =====
// ----------------------------------------------------------------------------
// dlsh_queue
// short request queue between the front and the back
// ----------------------------------------------------------------------------
`include "distance_lod_selector_hysteresis_core_assert.svh"

module dlsh_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dlsh_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output dlsh_pkg::t_item   o_item
);

    dlsh_pkg::t_item             r_mem [dlsh_pkg::QUEUE_DEPTH];
    logic [dlsh_pkg::QPTR_W-1:0] r_wptr;
    logic [dlsh_pkg::QPTR_W-1:0] r_rptr;
    logic [dlsh_pkg::QCNT_W-1:0] r_cnt;
    logic [dlsh_pkg::QPTR_W-1:0] n_wptr;
    logic [dlsh_pkg::QPTR_W-1:0] n_rptr;
    logic [dlsh_pkg::QCNT_W-1:0] n_cnt;
    logic                        w_push;
    logic                        w_pop;

    always_comb begin
        o_ready = (r_cnt != dlsh_pkg::QCNT_W'(dlsh_pkg::QUEUE_DEPTH));
        o_valid = (r_cnt != '0);
        o_item  = r_mem[r_rptr];
        w_push  = i_valid && o_ready;
        w_pop   = o_valid && i_ready;

        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == dlsh_pkg::QPTR_W'(dlsh_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == dlsh_pkg::QPTR_W'(dlsh_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    `DLSH_ASSERT_SAME(a_cnt_bound, 1'b1, r_cnt <= dlsh_pkg::QCNT_W'(dlsh_pkg::QUEUE_DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/dlsh_back.sv =====
// ----------------------------------------------------------------------------
// dlsh_back
// slot table read-modify-write and result register
// ----------------------------------------------------------------------------
`include "distance_lod_selector_hysteresis_core_assert.svh"

module dlsh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dlsh_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  dlsh_pkg::t_item   i_q_item,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output dlsh_pkg::t_rsp    o_rsp
);

    dlsh_pkg::t_slot   r_mem [dlsh_pkg::NUM_SLOTS];
    dlsh_pkg::t_slot   r_rd;
    dlsh_pkg::t_item   r_cur;
    dlsh_pkg::t_bstate r_state;
    dlsh_pkg::t_bstate n_state;
    logic [dlsh_pkg::NUM_SLOTS-1:0] r_alive;
    logic              r_out_valid;
    dlsh_pkg::t_rsp    r_out;

    logic              w_pop;
    logic              w_load;
    logic              w_fire;
    logic              w_alive;
    logic              w_wr;
    logic              w_set_alive;
    logic              w_hit;
    logic [6:0]        w_hold_inc;
    dlsh_pkg::t_slot   w_wdata;
    dlsh_pkg::t_rsp    w_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlsh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_load    = !r_out_valid || i_rsp_ready;
        w_pop     = 1'b0;
        w_fire    = 1'b0;
        o_q_ready = 1'b0;
        n_state   = r_state;
        case (r_state)
            dlsh_pkg::S_IDLE: begin
                o_q_ready = 1'b1;
                w_pop     = i_q_valid;
                if (i_q_valid) begin
                    n_state = dlsh_pkg::S_EXEC;
                end
            end
            dlsh_pkg::S_EXEC: begin
                w_fire = w_load;
                if (w_load) begin
                    n_state = dlsh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dlsh_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_alive     = r_cur.in_range && r_alive[r_cur.addr];
        w_wdata     = r_rd;
        w_rsp       = '0;
        w_wr        = 1'b0;
        w_set_alive = 1'b0;
        w_hit       = 1'b1;
        w_hold_inc  = (r_rd.hold == dlsh_pkg::HOLD_MAX) ? r_rd.hold : r_rd.hold + 1'b1;
        case (r_rd.committed)
            dlsh_pkg::TIER_RATE: w_hit = r_cur.hit_rate;
            dlsh_pkg::TIER_SKEL: w_hit = r_cur.hit_skel;
            dlsh_pkg::TIER_IMP:  w_hit = r_cur.hit_imp;
            default:             w_hit = 1'b1;
        endcase

        case (r_cur.mode)
            dlsh_pkg::MODE_OPEN: begin
                if (r_cur.in_range) begin
                    w_wr             = 1'b1;
                    w_set_alive      = 1'b1;
                    w_wdata          = '0;
                    w_rsp.slot_valid = 1'b1;
                end
            end
            dlsh_pkg::MODE_SELECT: begin
                if (w_alive) begin
                    w_wr             = 1'b1;
                    w_rsp.slot_valid = 1'b1;
                    if (r_cur.force_full) begin
                        w_wdata.committed = dlsh_pkg::TIER_FULL;
                        w_wdata.pending   = dlsh_pkg::TIER_FULL;
                        w_wdata.hold      = '0;
                    end else if (r_cur.want != r_rd.pending) begin
                        w_wdata.pending = r_cur.want;
                        w_wdata.hold    = '0;
                    end else begin
                        w_wdata.hold = w_hold_inc;
                        if (w_hold_inc >= i_cfg.hold_frames) begin
                            w_wdata.committed = r_cur.want;
                        end
                    end
                    w_rsp.tier = w_wdata.committed;
                end
            end
            dlsh_pkg::MODE_QUERY: begin
                if (!w_alive) begin
                    w_rsp.update_pose = 1'b1;
                end else begin
                    w_rsp.slot_valid = 1'b1;
                    w_rsp.tier       = r_rd.committed;
                    if (w_hit || !r_rd.upd_nz) begin
                        w_rsp.update_pose = 1'b1;
                        w_wr              = 1'b1;
                        w_wdata.upd_nz    = r_cur.frame_nz;
                    end
                end
            end
            default: begin
                w_rsp = '0;
            end
        endcase
    end

    // slot table, read on pop, written on completion
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rd  <= r_mem[i_q_item.addr];
            r_cur <= i_q_item;
        end
        if (w_fire && w_wr) begin
            r_mem[r_cur.addr] <= w_wdata;
        end
        if (w_fire) begin
            r_out <= w_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire && w_set_alive) begin
                r_alive[r_cur.addr] <= 1'b1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    `DLSH_ASSERT_NEXT(a_stall_holds, (r_state == dlsh_pkg::S_EXEC) && !w_load, (r_state == dlsh_pkg::S_EXEC) && $stable(r_cur), "request lost while result stalled")
    `DLSH_ASSERT_SAME(a_rsp_from_exec, $rose(r_out_valid), $past(r_state == dlsh_pkg::S_EXEC), "result without execution")
    `DLSH_ASSERT_NEXT(a_open_alive, w_fire && (r_cur.mode == dlsh_pkg::MODE_OPEN) && r_cur.in_range, r_alive[$past(r_cur.addr)], "opened slot not alive")

endmodule

// ===== rtl/distance_lod_selector_hysteresis_core.sv =====
// ----------------------------------------------------------------------------
// distance_lod_selector_hysteresis_core
// per-instance animation lod table with hysteresis on tier changes
// ----------------------------------------------------------------------------
// requests enter on i_req_valid / o_req_ready with an i_req payload; each
// request gives exactly one response on o_rsp_valid / i_rsp_ready with o_rsp.
// the front classifies a request in its accept cycle (wanted tier, frame
// phase) and pushes it into a two-entry queue; the back reads the slot table
// when it pops a request, then, once the response register is free, writes
// the slot back and loads the response register. the back takes a new
// request only after it has written back the previous one.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the
// user must write it only while no request is outstanding, and the block
// itself does not enforce this.
// reset closes every slot and loads the default registers; there is no
// clearing pass. when the receiver stalls the response register holds, the
// back waits and the queue fills, after which o_req_ready drops.
// ----------------------------------------------------------------------------
module distance_lod_selector_hysteresis_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  dlsh_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output dlsh_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [19:0]     i_cfg_wdata
);

    dlsh_pkg::t_cfg  r_cfg;
    dlsh_pkg::t_item w_push_item;
    dlsh_pkg::t_item w_pop_item;
    logic            w_push;
    logic            w_q_ready;
    logic            w_q_valid;
    logic            w_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lod_enable  <= 1'b1;
            r_cfg.lod_start   <= dlsh_pkg::RST_START;
            r_cfg.lod_end     <= dlsh_pkg::RST_END;
            r_cfg.hold_frames <= dlsh_pkg::RST_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dlsh_pkg::CFG_ENABLE: r_cfg.lod_enable  <= i_cfg_wdata[0];
                dlsh_pkg::CFG_START:  r_cfg.lod_start   <= i_cfg_wdata;
                dlsh_pkg::CFG_END:    r_cfg.lod_end     <= i_cfg_wdata;
                dlsh_pkg::CFG_HOLD:   r_cfg.hold_frames <= i_cfg_wdata[6:0];
                default:              r_cfg             <= r_cfg;
            endcase
        end
    end

    dlsh_front u_front (
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_cfg       (r_cfg),
        .o_push      (w_push),
        .o_item      (w_push_item),
        .i_q_ready   (w_q_ready)
    );

    dlsh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_push),
        .o_ready (w_q_ready),
        .i_item  (w_push_item),
        .o_valid (w_q_valid),
        .i_ready (w_pop_ready),
        .o_item  (w_pop_item)
    );

    dlsh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_pop_ready),
        .i_q_item    (w_pop_item),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== bench/distance_lod_selector_hysteresis_core_chk.sv =====
// ----------------------------------------------------------------------------
// distance_lod_selector_hysteresis_core_chk
// watches the request, response and register ports of the lod table, keeps
// its own copy of the slot table and registers, works out the response of
// every accepted request and compares each accepted response field by field
// with the oldest one still owed
// ----------------------------------------------------------------------------
module distance_lod_selector_hysteresis_core_chk
    import dlsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_req        i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_rsp        i_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_outstanding
);

    logic        lod_on;
    logic [19:0] near_dist;
    logic [19:0] far_dist;
    logic [6:0]  hold_need;

    logic        slot_live [NUM_SLOTS];
    logic [1:0]  tier_now  [NUM_SLOTS];
    logic [1:0]  tier_want [NUM_SLOTS];
    logic [6:0]  hold_cnt  [NUM_SLOTS];
    logic        seen_nz   [NUM_SLOTS];

    t_rsp        tier_replies_q [$];
    int          mismatches = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic logic [1:0] target_tier(t_req r);
        logic [21:0] s;
        logic [21:0] e;
        s = {2'b00, near_dist};
        e = {2'b00, far_dist};
        if (e <= s) begin
            e = s + 22'(ONE_FX);
        end
        if (!r.visible && !r.shadow_visible) begin
            return TIER_IMP;
        end
        if ({2'b00, r.distance} >= e || r.projected_size < MIN_SIZE_FX) begin
            return TIER_IMP;
        end
        if ({1'b0, r.distance, 1'b0} >= s + e) begin
            return TIER_SKEL;
        end
        if (r.distance >= near_dist) begin
            return TIER_RATE;
        end
        return TIER_FULL;
    endfunction

    function automatic t_rsp step_lod_table(t_req r);
        t_rsp        rsp;
        int unsigned idx;
        logic        ok_idx;
        logic        live;
        logic [1:0]  w;
        int unsigned period;
        rsp    = '0;
        idx    = r.instance_req;
        ok_idx = (idx != 0) && (idx < NUM_SLOTS);
        live   = ok_idx && slot_live[idx];
        case (t_mode'(r.mode))
            MODE_OPEN: begin
                if (ok_idx) begin
                    slot_live[idx] = 1'b1;
                    tier_now[idx]  = TIER_FULL;
                    tier_want[idx] = TIER_FULL;
                    hold_cnt[idx]  = '0;
                    seen_nz[idx]   = 1'b0;
                    rsp.slot_valid = 1'b1;
                end
            end
            MODE_SELECT: begin
                if (live) begin
                    rsp.slot_valid = 1'b1;
                    if (!lod_on || r.cinematic) begin
                        tier_now[idx]  = TIER_FULL;
                        tier_want[idx] = TIER_FULL;
                        hold_cnt[idx]  = '0;
                    end else begin
                        w = target_tier(r);
                        if (w != tier_want[idx]) begin
                            tier_want[idx] = w;
                            hold_cnt[idx]  = '0;
                        end else begin
                            if (hold_cnt[idx] < HOLD_MAX) begin
                                hold_cnt[idx] = hold_cnt[idx] + 7'd1;
                            end
                            if (hold_cnt[idx] >= hold_need) begin
                                tier_now[idx] = w;
                            end
                        end
                    end
                    rsp.tier = tier_now[idx];
                end
            end
            MODE_QUERY: begin
                if (!live) begin
                    rsp.update_pose = 1'b1;
                end else begin
                    rsp.slot_valid = 1'b1;
                    rsp.tier       = tier_now[idx];
                    case (tier_now[idx])
                        TIER_RATE: period = 2;
                        TIER_SKEL: period = 3;
                        TIER_IMP:  period = 8;
                        default:   period = 1;
                    endcase
                    if ((r.frame_index % period) == 0 || !seen_nz[idx]) begin
                        seen_nz[idx]    = (r.frame_index != 0);
                        rsp.update_pose = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp head;
        if (!i_rst_n) begin
            lod_on    = 1'b1;
            near_dist = RST_START;
            far_dist  = RST_END;
            hold_need = RST_HOLD;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_live[i] = 1'b0;
                tier_now[i]  = TIER_FULL;
                tier_want[i] = TIER_FULL;
                hold_cnt[i]  = '0;
                seen_nz[i]   = 1'b0;
            end
            tier_replies_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE: lod_on    = i_cfg_wdata[0];
                    CFG_START:  near_dist = i_cfg_wdata;
                    CFG_END:    far_dist  = i_cfg_wdata;
                    CFG_HOLD:   hold_need = i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (tier_replies_q.size() == 0) begin
                    $error("unrequested response: tier %0d update_pose %0b slot_valid %0b",
                           i_rsp.tier, i_rsp.update_pose, i_rsp.slot_valid);
                    mismatches++;
                end else begin
                    head = tier_replies_q.pop_front();
                    if (i_rsp.tier !== head.tier) begin
                        $error("tier: expected %0d, got %0d", head.tier, i_rsp.tier);
                        mismatches++;
                    end
                    if (i_rsp.update_pose !== head.update_pose) begin
                        $error("update_pose: expected %0b, got %0b",
                               head.update_pose, i_rsp.update_pose);
                        mismatches++;
                    end
                    if (i_rsp.slot_valid !== head.slot_valid) begin
                        $error("slot_valid: expected %0b, got %0b",
                               head.slot_valid, i_rsp.slot_valid);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                tier_replies_q.push_back(step_lod_table(i_req));
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= tier_replies_q.size();
    end

endmodule

// ===== bench/distance_lod_selector_hysteresis_core_tb.sv =====
// ----------------------------------------------------------------------------
// distance_lod_selector_hysteresis_core_tb
// drives the lod table with a short directed sequence and then phases of
// random open / select / query traffic under several register settings, with
// random gaps on both handshakes and one long response hold-off; the checker
// beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module distance_lod_selector_hysteresis_core_tb;
    import dlsh_pkg::*;

    localparam int PHASE_ITEMS    = 300;
    localparam int STALL_AT       = 1050;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int GAP_PCT        = 21;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    t_req        req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    t_rsp        rsp;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CFG_ENABLE;
    logic [19:0] cfg_wdata = '0;

    int          fail_count;
    int          outstanding;
    int          quiet_cycles = 0;
    int          req_count    = 0;
    int          sent         = 0;
    logic        gaps_on      = 1'b1;
    logic        stall_done   = 1'b0;
    logic        slot_opened [NUM_SLOTS];

    logic [19:0] near_set = RST_START;
    logic [19:0] far_set  = RST_END;

    always #5 i_clk = ~i_clk;

    distance_lod_selector_hysteresis_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    distance_lod_selector_hysteresis_core_chk i_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp         (rsp),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // receiver with one long hold-off while requests keep coming
    initial begin
        forever begin
            @(posedge i_clk);
            if (!stall_done && req_count >= STALL_AT) begin
                stall_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end else begin
                rsp_ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (req_valid && req_ready) begin
            req_count <= req_count + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("distance_lod_selector_hysteresis_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_req make_req(t_mode m, logic [5:0] slot, logic [19:0] d,
                                      logic [15:0] sz, logic vis, logic shv,
                                      logic cine, logic [31:0] frame);
        t_req r;
        r.mode           = m;
        r.instance_req   = slot;
        r.distance       = d;
        r.projected_size = sz;
        r.visible        = vis;
        r.shadow_visible = shv;
        r.cinematic      = cine;
        r.frame_index    = frame;
        return r;
    endfunction

    function automatic logic [19:0] pick_distance();
        int unsigned s;
        int unsigned e;
        int unsigned mid;
        s = near_set;
        e = far_set;
        if (e <= s) begin
            e = s + 16;
        end
        mid = (s + e + 1) / 2;
        case ($urandom_range(11))
            0: return 20'd0;
            1: return 20'hFFFFF;
            2: return 20'(s - 1);
            3: return 20'(s);
            4: return 20'(mid - 1);
            5: return 20'(mid);
            6: return 20'(e - 1);
            7: return 20'(e);
            8: return 20'($urandom());
            default: return 20'($urandom_range(e));
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return MIN_SIZE_FX - 16'd1;
            2: return MIN_SIZE_FX;
            3: return 16'hFFFF;
            4: return 16'($urandom());
            default: return 16'($urandom_range(64, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_frame();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return 32'(24 * $urandom_range(1000));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_req query_req(logic [5:0] slot);
        return make_req(MODE_QUERY, slot, 20'($urandom()), 16'($urandom()),
                        1'($urandom()), 1'($urandom()), 1'($urandom()), pick_frame());
    endfunction

    task automatic send(input t_req r);
        if (gaps_on && $urandom_range(99) < GAP_PCT) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge i_clk); while (!req_ready);
        if (r.mode != MODE_NONE) begin
            sent++;
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic en, input logic [19:0] s,
                                input logic [19:0] e, input logic [6:0] h);
        logic [1:0]  regs [4];
        logic [19:0] vals [4];
        regs[0] = CFG_ENABLE;
        regs[1] = CFG_START;
        regs[2] = CFG_END;
        regs[3] = CFG_HOLD;
        vals[0] = {19'd0, en};
        vals[1] = s;
        vals[2] = e;
        vals[3] = {13'd0, h};
        near_set = s;
        far_set  = e;
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= regs[k];
            cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic open_slot(input logic [5:0] slot);
        send(make_req(MODE_OPEN, slot, 20'($urandom()), 16'($urandom()),
                      1'($urandom()), 1'($urandom()), 1'($urandom()), $urandom()));
        slot_opened[slot] = 1'b1;
    endtask

    // one slot: open if needed or at random, selects with hysteresis, then queries
    task automatic run_episode();
        t_req        r;
        logic [5:0]  slot;
        int unsigned burst;
        slot = 6'($urandom_range(1, 63));
        if ($urandom_range(7) == 0) begin
            r = make_req(t_mode'($urandom_range(3)), 6'($urandom()), 20'($urandom()),
                         16'($urandom()), 1'($urandom()), 1'($urandom()),
                         1'($urandom()), $urandom());
            send(r);
            return;
        end
        if (!slot_opened[slot] || $urandom_range(11) == 0) begin
            open_slot(slot);
        end
        burst = ($urandom_range(24) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 12);
        r = make_req(MODE_SELECT, slot, pick_distance(), pick_size(),
                     $urandom_range(3) != 0, 1'($urandom()), 1'b0, $urandom());
        repeat (burst) begin
            if (burst <= 12 && $urandom_range(5) == 0) begin
                r.distance = pick_distance();
            end
            r.cinematic = (burst <= 12) && ($urandom_range(19) == 0);
            send(r);
            if ($urandom_range(9) == 0) begin
                send(query_req(slot));
            end
        end
        repeat ($urandom_range(1, 3)) send(query_req(slot));
    endtask

    task automatic run_random(input int n);
        int first;
        first = sent;
        while (sent - first < n) begin
            run_episode();
        end
    endtask

    initial begin
        int unsigned s;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_opened[i] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset register values
        send(make_req(MODE_SELECT, 6'd5, 20'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 32'd0));
        send(make_req(MODE_QUERY, 6'd5, 20'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd7));
        send(make_req(MODE_OPEN, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        send(make_req(MODE_NONE, 6'd1, 20'd100, 16'd100, 1'b1, 1'b0, 1'b0, 32'd1));
        open_slot(6'd1);
        open_slot(6'd63);
        send(make_req(MODE_QUERY, 6'd1, 20'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        send(make_req(MODE_QUERY, 6'd1, 20'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'hFFFFFFFF));
        send(make_req(MODE_SELECT, 6'd1, 20'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 32'd0));
        send(make_req(MODE_SELECT, 6'd1, 20'hFFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 32'd0));
        send(make_req(MODE_SELECT, 6'd1, 20'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 32'd0));
        send(make_req(MODE_SELECT, 6'd1, RST_START, MIN_SIZE_FX, 1'b0, 1'b1, 1'b0, 32'd0));
        send(make_req(MODE_SELECT, 6'd1, 20'd0, MIN_SIZE_FX - 16'd1, 1'b1, 1'b1, 1'b0,
                      32'd0));
        send(make_req(MODE_SELECT, 6'd1, 20'hFFFFF, 16'd0, 1'b0, 1'b0, 1'b1, 32'd0));
        send(make_req(MODE_SELECT, 6'd63, 20'd24000, 16'd4000, 1'b1, 1'b0, 1'b0, 32'd0));
        send(make_req(MODE_SELECT, 6'd63, 20'd23999, 16'd4000, 1'b1, 1'b0, 1'b0, 32'd0));
        send(make_req(MODE_SELECT, 6'd63, RST_END - 20'd1, 16'd4000, 1'b1, 1'b1, 1'b0,
                      32'd0));
        send(make_req(MODE_QUERY, 6'd63, 20'd0, 16'd0, 1'b1, 1'b1, 1'b1, 32'h12345678));
        open_slot(6'd63);
        send(make_req(MODE_SELECT, 6'd0, 20'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 32'd0));
        send(make_req(MODE_QUERY, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd3));
        send(make_req(MODE_NONE, 6'd63, 20'hFFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1,
                      32'hFFFFFFFF));

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: program_regs(1'b1, RST_START, RST_END, 7'd0);
                1: program_regs(1'b1, 20'd0, 20'd0, 7'd64);
                2: program_regs(1'b0, 20'($urandom()), 20'($urandom()),
                                7'($urandom_range(64)));
                3: program_regs(1'b1, 20'hFFFFF, 20'hFFFFF, 7'd1);
                4: program_regs(1'b1, 20'd200, 20'd100, 7'd3);
                default: begin
                    s = $urandom_range(60000);
                    program_regs(1'b1, 20'(s), 20'(s + $urandom_range(16, 60000)),
                                 7'($urandom_range(64)));
                end
            endcase
            gaps_on <= (p != 2);
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("distance_lod_selector_hysteresis_core verification clean");
        end else begin
            $display("distance_lod_selector_hysteresis_core verification failed");
        end
        $finish;
    end

endmodule
